// File: src/plid_pkg.sv
// Shared constants, codes and types for the positional list block.
package plid_pkg;

  // Number of entries the list can hold.
  localparam int CAPACITY = 16;

  // Field widths of the command and response transactions.
  localparam int CMD_W  = 3;
  localparam int POS_W  = 5;
  localparam int DATA_W = 32;
  localparam int STAT_W = 2;

  // Internal widths that follow from the capacity.
  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR  = 3'd0,
    CMD_APPEND = 3'd1,
    CMD_INSERT = 3'd2,
    CMD_DELETE = 3'd3,
    CMD_READ   = 3'd4
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 2'd0,
    ST_BAD_POS = 2'd1,
    ST_FULL    = 2'd2,
    ST_EMPTY   = 2'd3
  } status_t;

endpackage

// File: src/plid_if.sv
// Command and response channel interfaces of the positional list block.
interface plid_cmd_if;
  import plid_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [CMD_W-1:0]         command;
  logic [POS_W-1:0]         position;
  logic signed [DATA_W-1:0] item_value;

  modport source (output valid, output command, output position, output item_value,
                  input ready);
  modport sink   (input valid, input command, input position, input item_value,
                  output ready);
endinterface

interface plid_rsp_if;
  import plid_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] out_value;
  logic [POS_W-1:0]         list_length;
  logic [STAT_W-1:0]        status;

  modport source (output valid, output out_value, output list_length, output status,
                  input ready);
  modport sink   (input valid, input out_value, input list_length, input status,
                  output ready);
endinterface

// File: src/positional_list_insert_delete.sv
// Top level of the positional list: command decode, entry memory and shift sequencer.
//
// Usage: each transaction on the request channel carries one command (clear,
// append, insert after a position, delete at a position, read at a position).
// Every command yields exactly one transaction on the response channel with
// the removed or read value, the list length after the command and a status.
// Failed commands leave the list unchanged and return a zero value.
//
// The entries live packed in one synchronous memory with one write port and
// one read port (read data registered). Insert and delete move the entries
// after the position one per cycle through that memory, reading one entry
// and writing the previous one back in the same cycle.
//
// Clear, append, insert at the tail and every failed command finish without
// moving entries; other inserts, deletes and reads step through the entries
// they touch (a read touches one). One command is in flight at a time;
// request.ready is high once the previous command has left for the output
// register.
//
// Reset clears the length to zero and drops any pending response. When the
// receiver stalls, the finished response waits in the output register and
// one further command may be accepted and worked off behind it.
module positional_list_insert_delete (
  input logic        clk,
  input logic        rst,
  plid_cmd_if.sink   request,
  plid_rsp_if.source response
);
  import plid_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_MOVE = 3'b010,
    S_DONE = 3'b100
  } state_t;

  // Entry memory.
  logic [DATA_W-1:0] mem [CAPACITY];
  logic [DATA_W-1:0] rdata;
  logic              rd_en;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  logic [DATA_W-1:0] wr_data;

  // Control state.
  state_t            state;
  logic [CNT_W-1:0]  count;
  cmd_t              op;
  logic [IDX_W-1:0]  src;
  logic [IDX_W-1:0]  last_src;
  logic [CNT_W-1:0]  rd_left;
  logic              pend;
  logic              first;
  logic [IDX_W-1:0]  hold_pos;
  logic [DATA_W-1:0] hold_val;
  logic [DATA_W-1:0] res_value;
  status_t           res_status;

  // Output register.
  logic                     out_valid;
  logic signed [DATA_W-1:0] out_value;
  logic [POS_W-1:0]         out_length;
  logic [STAT_W-1:0]        out_status;

  // Decode helpers.
  logic             accept;
  cmd_t             cmd;
  logic [CMP_W-1:0] pos_ext;
  logic [CMP_W-1:0] cnt_ext;
  logic             full;
  logic             empty;
  logic             tail_ins;
  logic             move_done;

  assign accept    = request.valid && request.ready;
  assign cmd       = cmd_t'(request.command);
  assign pos_ext   = CMP_W'(request.position);
  assign cnt_ext   = CMP_W'(count);
  assign full      = (count == CNT_W'(CAPACITY));
  assign empty     = (count == '0);
  assign tail_ins  = (pos_ext == cnt_ext);
  assign move_done = (rd_left == '0) && !pend;

  assign request.ready = (state == S_IDLE);

  // Read one entry per cycle while reads remain.
  assign rd_en = (state == S_MOVE) && (rd_left != '0);

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata <= mem[src];
    end
  end

  // Select the single write: tail write at accept, shifted entry or the new value.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = src;
    wr_data = rdata;
    if (state == S_IDLE && accept) begin
      if (cmd == CMD_APPEND && !full) begin
        wr_en   = 1'b1;
        wr_addr = IDX_W'(count);
        wr_data = request.item_value;
      end else if (cmd == CMD_INSERT && !full && tail_ins) begin
        wr_en   = 1'b1;
        wr_addr = IDX_W'(count);
        wr_data = request.item_value;
      end
    end else if (state == S_MOVE) begin
      if (pend && op == CMD_INSERT) begin
        wr_en   = 1'b1;
        wr_addr = last_src + IDX_W'(1);
      end else if (pend && op == CMD_DELETE && !first) begin
        wr_en   = 1'b1;
        wr_addr = last_src - IDX_W'(1);
      end else if (move_done && op == CMD_INSERT) begin
        wr_en   = 1'b1;
        wr_addr = hold_pos;
        wr_data = hold_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Command sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      count   <= '0;
      rd_left <= '0;
      pend    <= 1'b0;
      first   <= 1'b0;
      op      <= CMD_CLEAR;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            res_value  <= '0;
            res_status <= ST_OK;
            op         <= cmd;
            hold_val   <= request.item_value;
            hold_pos   <= IDX_W'(pos_ext);
            pend       <= 1'b0;
            first      <= 1'b1;
            state      <= S_DONE;
            case (cmd) inside
              CMD_CLEAR: begin
                count <= '0;
              end
              CMD_APPEND: begin
                if (full) begin
                  res_status <= ST_FULL;
                end else begin
                  count <= count + CNT_W'(1);
                end
              end
              CMD_INSERT: begin
                if (full) begin
                  res_status <= ST_FULL;
                end else if (pos_ext > cnt_ext) begin
                  res_status <= ST_BAD_POS;
                end else if (tail_ins) begin
                  count <= count + CNT_W'(1);
                end else begin
                  src     <= IDX_W'(count - CNT_W'(1));
                  rd_left <= CNT_W'(cnt_ext - pos_ext);
                  state   <= S_MOVE;
                end
              end
              CMD_DELETE, CMD_READ: begin
                if (empty) begin
                  res_status <= ST_EMPTY;
                end else if (pos_ext == '0 || pos_ext > cnt_ext) begin
                  res_status <= ST_BAD_POS;
                end else begin
                  src     <= IDX_W'(pos_ext - CMP_W'(1));
                  rd_left <= (cmd == CMD_READ) ? CNT_W'(1)
                                               : CNT_W'(cnt_ext - pos_ext + CMP_W'(1));
                  state   <= S_MOVE;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_MOVE: begin
          // Issue the next read and advance the source pointer.
          if (rd_left != '0) begin
            last_src <= src;
            pend     <= 1'b1;
            rd_left  <= rd_left - CNT_W'(1);
            src      <= (op == CMD_INSERT) ? src - IDX_W'(1) : src + IDX_W'(1);
          end else begin
            pend <= 1'b0;
          end
          // Capture the addressed value on the first returned read.
          if (pend) begin
            first <= 1'b0;
            if (first && op != CMD_INSERT) begin
              res_value <= rdata;
            end
          end
          // Close out: adjust the length once all moves are written.
          if (move_done) begin
            if (op == CMD_INSERT) begin
              count <= count + CNT_W'(1);
            end else if (op == CMD_DELETE) begin
              count <= count - CNT_W'(1);
            end
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || response.ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Output register: load when free, drop when taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && (!out_valid || response.ready)) begin
      out_valid <= 1'b1;
    end else if (response.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && (!out_valid || response.ready)) begin
      out_value  <= res_value;
      out_length <= POS_W'(count);
      out_status <= res_status;
    end
  end

  assign response.valid       = out_valid;
  assign response.out_value   = out_value;
  assign response.list_length = out_length;
  assign response.status      = out_status;

endmodule

// File: src/plid_checker.sv
// Port-level checks of the positional list block and their bind.
module plid_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               rsp_valid,
  input logic                               rsp_ready,
  input logic signed [plid_pkg::DATA_W-1:0] rsp_value,
  input logic [plid_pkg::POS_W-1:0]         rsp_length,
  input logic [plid_pkg::STAT_W-1:0]        rsp_status
);
  import plid_pkg::*;

  // Hold a stalled response.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value) && $stable(rsp_length)
      && $stable(rsp_status))
    else $error("stalled response changed");

  // Reset drops any pending response.
  a_rst_idle: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("response valid after reset");

  // Failed commands return a zero value.
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status != ST_OK |-> rsp_value == '0)
    else $error("failed command returned a value");

  // A full report comes with a full list.
  a_full_len: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status == ST_FULL |-> rsp_length == POS_W'(CAPACITY))
    else $error("full status with wrong length");

  // An empty report comes with an empty list.
  a_empty_len: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status == ST_EMPTY |-> rsp_length == '0)
    else $error("empty status with nonzero length");

endmodule

bind positional_list_insert_delete plid_checker u_plid_checker (
  .clk        (clk),
  .rst        (rst),
  .rsp_valid  (response.valid),
  .rsp_ready  (response.ready),
  .rsp_value  (response.out_value),
  .rsp_length (response.list_length),
  .rsp_status (response.status)
);
